@@ design/tcc_pkg.sv @@
`timescale 1ns / 1ps
// shared types, codes and color table for the text console cursor controller
// no dependencies; used by tcc_cursor, the top level and the checker

package tcc_pkg;

   localparam int COL_W     = 10;
   localparam int LINE_W    = 10;
   localparam int CHAR_W    = 8;
   localparam int COLOR_W   = 8;
   localparam int SEL_W     = 4;
   localparam int CSR_W     = 10;
   localparam int RES_CNT_W = 5;
   localparam int ACC_W     = 6;
   localparam int SUM_W     = 10;

   localparam logic [COL_W-1:0]     RESET_LAST_COLUMN = 10'd127;
   localparam logic [LINE_W-1:0]    RESET_LAST_LINE   = 10'd47;
   localparam logic [RES_CNT_W-1:0] MAX_RESULTS       = 5'd16;
   localparam logic [SEL_W-1:0]     SEL_DEFAULT       = 4'd8;
   localparam logic [COLOR_W-1:0]   GRAY_LEVEL        = 8'hcc;

   // sgr color codes, kept narrow with a sticky overflow
   localparam logic [ACC_W-1:0] SGR_RESET    = 6'd0;
   localparam logic [ACC_W-1:0] SGR_FG_FIRST = 6'd30;
   localparam logic [ACC_W-1:0] SGR_FG_LAST  = 6'd37;
   localparam logic [SUM_W-1:0] SGR_OVER     = 10'd38;

   // byte codes
   localparam logic [CHAR_W-1:0] CH_BEL  = 8'd7;
   localparam logic [CHAR_W-1:0] CH_BS   = 8'd8;
   localparam logic [CHAR_W-1:0] CH_HT   = 8'd9;
   localparam logic [CHAR_W-1:0] CH_LF   = 8'd10;
   localparam logic [CHAR_W-1:0] CH_VT   = 8'd11;
   localparam logic [CHAR_W-1:0] CH_CR   = 8'd13;
   localparam logic [CHAR_W-1:0] CH_ESC  = 8'd27;
   localparam logic [CHAR_W-1:0] CH_ZERO = 8'h30;
   localparam logic [CHAR_W-1:0] CH_NINE = 8'h39;
   localparam logic [CHAR_W-1:0] CH_LBR  = 8'h5b;
   localparam logic [CHAR_W-1:0] CH_M    = 8'h6d;

   // register indexes
   localparam logic CSR_LAST_COLUMN = 1'b0;
   localparam logic CSR_LAST_LINE   = 1'b1;

   typedef enum logic [1:0] {
      PH_IDLE,
      PH_ESC,
      PH_CSI
   } tcc_phase_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_BYTE,
      ST_DRAW,
      ST_SCROLL,
      ST_DIGIT,
      ST_ACC,
      ST_CHECK,
      ST_TAB_MUL,
      ST_TAB_REM,
      ST_TAB_APPLY,
      ST_FLUSH
   } tcc_state_type;

   typedef enum logic [1:0] {
      AFT_BYTE,
      AFT_DIGITS,
      AFT_DONE
   } tcc_after_type;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_ADVANCE,
      OP_NEWLINE,
      OP_CR,
      OP_LINEDOWN,
      OP_BACK,
      OP_TAB_MUL,
      OP_TAB_REM,
      OP_TAB_APPLY
   } tcc_op_type;

   typedef struct packed {
      logic [COL_W-1:0]  column;
      logic [LINE_W-1:0] line;
      logic              scroll;
   } tcc_cursor_type;

   typedef struct packed {
      logic               kind;
      logic [CHAR_W-1:0]  glyph;
      logic [COL_W-1:0]   column;
      logic [LINE_W-1:0]  line;
      logic [COLOR_W-1:0] red;
      logic [COLOR_W-1:0] green;
      logic [COLOR_W-1:0] blue;
   } tcc_result_type;

   localparam logic [3*COLOR_W-1:0] PALETTE [8] = '{
      24'h000000, 24'h800000, 24'h008000, 24'h808000,
      24'h000080, 24'h800080, 24'h008080, 24'hffffff
   };

   function automatic logic [3*COLOR_W-1:0] color_rgb(input logic [SEL_W-1:0] sel);
      logic [3*COLOR_W-1:0] rgb;
      if (sel < SEL_DEFAULT) begin
         rgb = PALETTE[sel[2:0]];
      end else begin
         rgb = {GRAY_LEVEL, GRAY_LEVEL, GRAY_LEVEL};
      end
      return rgb;
   endfunction

endpackage

@@ design/text_console_cursor_controller_top.sv @@
`timescale 1ns / 1ps
// top level of the text console cursor controller: escape parser, sequencer,
// color state and result registers; depends on tcc_pkg and tcc_cursor
//
//   channel  | ports                          | beat
//   ---------+--------------------------------+------------------------------
//   req      | req_valid/req_ready            | one character byte
//   rsp      | rsp_valid/rsp_ready            | one draw or scroll command
//   csr      | csr_we, csr_index, csr_wdata   | one register write, no wait
//
// after its beat a printable byte holds req_ready low for decode, draw and close
// out of the last beat, a tab for multiply, remainder and apply, and the 'm' of a
// color sequence for an accumulate per digit and a check; a failed sequence replays
// '[' and each held digit, and scrolls; tcc_cursor's shared unit sets this pace.
// reset is synchronous: cursor home, default gray, parser idle, limits 127/47.
// a result beat that is not taken holds the sequencer at its next result.

module text_console_cursor_controller_top #(
   parameter int MAX_ESC_DIGITS = 6,
   parameter int TAB_STOP       = 8
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [tcc_pkg::CHAR_W-1:0]      req_char_code,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic                            rsp_kind,
   output logic [tcc_pkg::CHAR_W-1:0]      rsp_glyph,
   output logic [tcc_pkg::COL_W-1:0]       rsp_column,
   output logic [tcc_pkg::LINE_W-1:0]      rsp_line,
   output logic [tcc_pkg::COLOR_W-1:0]     rsp_red,
   output logic [tcc_pkg::COLOR_W-1:0]     rsp_green,
   output logic [tcc_pkg::COLOR_W-1:0]     rsp_blue,
   output logic                            rsp_last,
   input  logic                            csr_we,
   input  logic                            csr_index,
   input  logic [tcc_pkg::CSR_W-1:0]       csr_wdata
);

   localparam int CNT_W = $clog2(MAX_ESC_DIGITS + 1);
   localparam int IDX_W = $clog2(MAX_ESC_DIGITS);

   // configuration
   logic [tcc_pkg::COL_W-1:0]  last_col_ff;
   logic [tcc_pkg::LINE_W-1:0] last_line_ff;

   // sequencer and parser state
   tcc_pkg::tcc_state_type state_ff, state_in;
   tcc_pkg::tcc_phase_type phase_ff, phase_in;
   tcc_pkg::tcc_after_type after_ff, after_in;
   logic [CNT_W-1:0]            dcount_ff, dcount_in;
   logic [CNT_W-1:0]            idx_ff, idx_in;
   logic [tcc_pkg::ACC_W-1:0]   acc_ff, acc_in;
   logic                        big_ff, big_in;
   logic [tcc_pkg::CHAR_W-1:0]  char_ff, char_in;
   logic [tcc_pkg::CHAR_W-1:0]  glyph_ff, glyph_in;
   logic [tcc_pkg::SEL_W-1:0]   color_ff, color_in;
   logic [3:0]                  held_ff [MAX_ESC_DIGITS];
   logic                        held_we;
   logic [3:0]                  held_wdata;

   // result path: a pending beat waits until it is known whether more follow
   tcc_pkg::tcc_result_type     pend_ff, pend_in, res_new, out_ff;
   logic                        pend_valid_ff, pend_valid_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic                        rsp_last_ff, out_last_in;
   logic                        out_load;
   logic [tcc_pkg::RES_CNT_W-1:0] res_cnt_ff, res_cnt_in;

   tcc_pkg::tcc_op_type         op;
   tcc_pkg::tcc_cursor_type     cur;

   logic                        accept;
   logic                        out_free;
   logic                        emit_now;
   logic                        emit_go;
   logic                        stall;
   logic                        in_digit;
   logic [tcc_pkg::CHAR_W-1:0]  digit_val;
   logic [3:0]                  held_rd;
   logic [tcc_pkg::SUM_W-1:0]   acc_sum;
   logic                        sgr_ok;
   logic [3*tcc_pkg::COLOR_W-1:0] rgb;
   tcc_pkg::tcc_state_type      after_state;

   assign req_ready = (state_ff == tcc_pkg::ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   // a result is produced only in the draw and scroll steps; beyond the cap
   // results are dropped but the cursor still moves
   assign emit_now = (state_ff == tcc_pkg::ST_DRAW) || (state_ff == tcc_pkg::ST_SCROLL);
   assign emit_go  = emit_now && (res_cnt_ff < tcc_pkg::MAX_RESULTS);
   assign stall    = emit_go && pend_valid_ff && !out_free;

   assign in_digit  = (req_char_code >= tcc_pkg::CH_ZERO) &&
                      (req_char_code <= tcc_pkg::CH_NINE);
   assign digit_val = req_char_code - tcc_pkg::CH_ZERO;
   assign held_rd   = held_ff[idx_ff[IDX_W-1:0]];

   // decimal accumulate, one digit a cycle; values past 37 only set a flag
   assign acc_sum = (tcc_pkg::SUM_W'(acc_ff) << 3) + (tcc_pkg::SUM_W'(acc_ff) << 1) +
                    tcc_pkg::SUM_W'(held_rd);
   assign sgr_ok  = !big_ff && ((acc_ff == tcc_pkg::SGR_RESET) ||
                    ((acc_ff >= tcc_pkg::SGR_FG_FIRST) && (acc_ff <= tcc_pkg::SGR_FG_LAST)));

   assign rgb = tcc_pkg::color_rgb(color_ff);

   always_comb begin
      res_new = '0;
      if (state_ff == tcc_pkg::ST_DRAW) begin
         res_new.kind   = 1'b0;
         res_new.glyph  = glyph_ff;
         res_new.column = cur.column;
         res_new.line   = cur.line;
         res_new.red    = rgb[3*tcc_pkg::COLOR_W-1:2*tcc_pkg::COLOR_W];
         res_new.green  = rgb[2*tcc_pkg::COLOR_W-1:tcc_pkg::COLOR_W];
         res_new.blue   = rgb[tcc_pkg::COLOR_W-1:0];
      end else begin
         res_new.kind = 1'b1;
      end
   end

   // where a finished draw or scroll goes next
   always_comb begin
      unique case (after_ff)
         tcc_pkg::AFT_BYTE:   after_state = tcc_pkg::ST_BYTE;
         tcc_pkg::AFT_DIGITS: after_state = tcc_pkg::ST_DIGIT;
         default:             after_state = tcc_pkg::ST_FLUSH;
      endcase
   end

   tcc_cursor #(
      .TAB_STOP (TAB_STOP)
   ) u_cursor (
      .clock       (clock),
      .reset       (reset),
      .op          (op),
      .last_column (last_col_ff),
      .last_line   (last_line_ff),
      .cur         (cur)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         tcc_pkg::ST_IDLE: begin
            if (accept) begin
               if (phase_ff == tcc_pkg::PH_ESC) begin
                  state_in = (req_char_code == tcc_pkg::CH_LBR) ? tcc_pkg::ST_IDLE
                                                                 : tcc_pkg::ST_DRAW;
               end else if (phase_ff == tcc_pkg::PH_CSI) begin
                  if (in_digit && (dcount_ff < CNT_W'(MAX_ESC_DIGITS))) begin
                     state_in = tcc_pkg::ST_IDLE;
                  end else if ((req_char_code == tcc_pkg::CH_M) && (dcount_ff != '0)) begin
                     state_in = tcc_pkg::ST_ACC;
                  end else begin
                     state_in = tcc_pkg::ST_DRAW;
                  end
               end else begin
                  state_in = tcc_pkg::ST_BYTE;
               end
            end
         end
         tcc_pkg::ST_BYTE: begin
            case (char_ff) inside
               tcc_pkg::CH_LF, tcc_pkg::CH_VT:
                  state_in = cur.scroll ? tcc_pkg::ST_SCROLL : tcc_pkg::ST_FLUSH;
               tcc_pkg::CH_ESC, tcc_pkg::CH_CR, tcc_pkg::CH_BEL, tcc_pkg::CH_BS:
                  state_in = tcc_pkg::ST_FLUSH;
               tcc_pkg::CH_HT:
                  state_in = tcc_pkg::ST_TAB_MUL;
               default:
                  state_in = tcc_pkg::ST_DRAW;
            endcase
         end
         tcc_pkg::ST_DRAW: begin
            if (!stall) begin
               state_in = cur.scroll ? tcc_pkg::ST_SCROLL : after_state;
            end
         end
         tcc_pkg::ST_SCROLL: begin
            if (!stall) begin
               state_in = after_state;
            end
         end
         tcc_pkg::ST_DIGIT: begin
            state_in = (idx_ff < dcount_ff) ? tcc_pkg::ST_DRAW : tcc_pkg::ST_BYTE;
         end
         tcc_pkg::ST_ACC: begin
            if (idx_ff == dcount_ff - CNT_W'(1)) begin
               state_in = tcc_pkg::ST_CHECK;
            end
         end
         tcc_pkg::ST_CHECK: begin
            state_in = sgr_ok ? tcc_pkg::ST_FLUSH : tcc_pkg::ST_DRAW;
         end
         tcc_pkg::ST_TAB_MUL: begin
            state_in = tcc_pkg::ST_TAB_REM;
         end
         tcc_pkg::ST_TAB_REM: begin
            state_in = tcc_pkg::ST_TAB_APPLY;
         end
         tcc_pkg::ST_TAB_APPLY: begin
            state_in = cur.scroll ? tcc_pkg::ST_SCROLL : tcc_pkg::ST_FLUSH;
         end
         tcc_pkg::ST_FLUSH: begin
            if (!pend_valid_ff || out_free) begin
               state_in = tcc_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = tcc_pkg::ST_IDLE;
         end
      endcase
   end

   // sequencer outputs and datapath register updates
   always_comb begin
      op         = tcc_pkg::OP_NONE;
      phase_in   = phase_ff;
      after_in   = after_ff;
      dcount_in  = dcount_ff;
      idx_in     = idx_ff;
      acc_in     = acc_ff;
      big_in     = big_ff;
      char_in    = char_ff;
      glyph_in   = glyph_ff;
      color_in   = color_ff;
      held_we    = 1'b0;
      held_wdata = digit_val[3:0];
      unique case (state_ff)
         tcc_pkg::ST_IDLE: begin
            if (accept) begin
               char_in = req_char_code;
               if (phase_ff == tcc_pkg::PH_ESC) begin
                  if (req_char_code == tcc_pkg::CH_LBR) begin
                     phase_in  = tcc_pkg::PH_CSI;
                     dcount_in = '0;
                  end else begin
                     // lone esc is drawn, then the byte runs as plain text
                     phase_in = tcc_pkg::PH_IDLE;
                     glyph_in = tcc_pkg::CH_ESC;
                     after_in = tcc_pkg::AFT_BYTE;
                  end
               end else if (phase_ff == tcc_pkg::PH_CSI) begin
                  if (in_digit && (dcount_ff < CNT_W'(MAX_ESC_DIGITS))) begin
                     held_we   = 1'b1;
                     dcount_in = dcount_ff + CNT_W'(1);
                  end else if ((req_char_code == tcc_pkg::CH_M) && (dcount_ff != '0)) begin
                     idx_in = '0;
                     acc_in = '0;
                     big_in = 1'b0;
                  end else begin
                     // failed sequence: replay '[' and the held digits
                     phase_in = tcc_pkg::PH_IDLE;
                     glyph_in = tcc_pkg::CH_LBR;
                     after_in = tcc_pkg::AFT_DIGITS;
                     idx_in   = '0;
                  end
               end
            end
         end
         tcc_pkg::ST_BYTE: begin
            case (char_ff) inside
               tcc_pkg::CH_ESC: begin
                  phase_in = tcc_pkg::PH_ESC;
               end
               tcc_pkg::CH_LF: begin
                  op       = tcc_pkg::OP_NEWLINE;
                  after_in = tcc_pkg::AFT_DONE;
               end
               tcc_pkg::CH_VT: begin
                  op       = tcc_pkg::OP_LINEDOWN;
                  after_in = tcc_pkg::AFT_DONE;
               end
               tcc_pkg::CH_CR: begin
                  op = tcc_pkg::OP_CR;
               end
               tcc_pkg::CH_BS: begin
                  op = tcc_pkg::OP_BACK;
               end
               tcc_pkg::CH_BEL, tcc_pkg::CH_HT: begin
               end
               default: begin
                  glyph_in = char_ff;
                  after_in = tcc_pkg::AFT_DONE;
               end
            endcase
         end
         tcc_pkg::ST_DRAW: begin
            op = stall ? tcc_pkg::OP_NONE : tcc_pkg::OP_ADVANCE;
         end
         tcc_pkg::ST_SCROLL: begin
         end
         tcc_pkg::ST_DIGIT: begin
            if (idx_ff < dcount_ff) begin
               glyph_in = tcc_pkg::CH_ZERO + tcc_pkg::CHAR_W'(held_rd);
               idx_in   = idx_ff + CNT_W'(1);
            end else begin
               dcount_in = '0;
            end
         end
         tcc_pkg::ST_ACC: begin
            acc_in = acc_sum[tcc_pkg::ACC_W-1:0];
            big_in = big_ff || (acc_sum >= tcc_pkg::SGR_OVER);
            idx_in = idx_ff + CNT_W'(1);
         end
         tcc_pkg::ST_CHECK: begin
            phase_in = tcc_pkg::PH_IDLE;
            if (sgr_ok) begin
               dcount_in = '0;
               if (acc_ff == tcc_pkg::SGR_RESET) begin
                  color_in = tcc_pkg::SEL_DEFAULT;
               end else begin
                  color_in = tcc_pkg::SEL_W'(acc_ff - tcc_pkg::SGR_FG_FIRST);
               end
            end else begin
               glyph_in = tcc_pkg::CH_LBR;
               after_in = tcc_pkg::AFT_DIGITS;
               idx_in   = '0;
            end
         end
         tcc_pkg::ST_TAB_MUL: begin
            op = tcc_pkg::OP_TAB_MUL;
         end
         tcc_pkg::ST_TAB_REM: begin
            op = tcc_pkg::OP_TAB_REM;
         end
         tcc_pkg::ST_TAB_APPLY: begin
            op       = tcc_pkg::OP_TAB_APPLY;
            after_in = tcc_pkg::AFT_DONE;
         end
         tcc_pkg::ST_FLUSH: begin
         end
         default: begin
         end
      endcase
   end

   // result staging: the newest beat waits in pend_ff; it moves out when the
   // next one arrives (not last) or when the byte is finished (last)
   always_comb begin
      out_load      = 1'b0;
      out_last_in   = 1'b0;
      pend_in       = pend_ff;
      pend_valid_in = pend_valid_ff;
      res_cnt_in    = res_cnt_ff;
      if (accept) begin
         res_cnt_in = '0;
      end
      if (emit_go && !stall) begin
         out_load      = pend_valid_ff;
         pend_in       = res_new;
         pend_valid_in = 1'b1;
         res_cnt_in    = res_cnt_ff + tcc_pkg::RES_CNT_W'(1);
      end
      if ((state_ff == tcc_pkg::ST_FLUSH) && pend_valid_ff && out_free) begin
         out_load      = 1'b1;
         out_last_in   = 1'b1;
         pend_valid_in = 1'b0;
      end
      if (out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= tcc_pkg::ST_IDLE;
         phase_ff      <= tcc_pkg::PH_IDLE;
         after_ff      <= tcc_pkg::AFT_DONE;
         dcount_ff     <= '0;
         color_ff      <= tcc_pkg::SEL_DEFAULT;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         res_cnt_ff    <= '0;
         last_col_ff   <= tcc_pkg::RESET_LAST_COLUMN;
         last_line_ff  <= tcc_pkg::RESET_LAST_LINE;
      end else begin
         state_ff      <= state_in;
         phase_ff      <= phase_in;
         after_ff      <= after_in;
         dcount_ff     <= dcount_in;
         color_ff      <= color_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         res_cnt_ff    <= res_cnt_in;
         if (csr_we) begin
            unique case (csr_index)
               tcc_pkg::CSR_LAST_COLUMN: last_col_ff  <= csr_wdata[tcc_pkg::COL_W-1:0];
               tcc_pkg::CSR_LAST_LINE:   last_line_ff <= csr_wdata[tcc_pkg::LINE_W-1:0];
               default: begin
               end
            endcase
         end
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      idx_ff   <= idx_in;
      acc_ff   <= acc_in;
      big_ff   <= big_in;
      char_ff  <= char_in;
      glyph_ff <= glyph_in;
      pend_ff  <= pend_in;
      if (held_we) begin
         held_ff[dcount_ff[IDX_W-1:0]] <= held_wdata;
      end
      if (out_load) begin
         out_ff      <= pend_ff;
         rsp_last_ff <= out_last_in;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_kind   = out_ff.kind;
   assign rsp_glyph  = out_ff.glyph;
   assign rsp_column = out_ff.column;
   assign rsp_line   = out_ff.line;
   assign rsp_red    = out_ff.red;
   assign rsp_green  = out_ff.green;
   assign rsp_blue   = out_ff.blue;
   assign rsp_last   = rsp_last_ff;

endmodule

@@ design/tcc_cursor.sv @@
`timescale 1ns / 1ps
// cursor position registers and the shared arithmetic unit that moves them
// depends on tcc_pkg

module tcc_cursor #(
   parameter int TAB_STOP = 8
) (
   input  logic                          clock,
   input  logic                          reset,
   input  tcc_pkg::tcc_op_type           op,
   input  logic [tcc_pkg::COL_W-1:0]     last_column,
   input  logic [tcc_pkg::LINE_W-1:0]    last_line,
   output tcc_pkg::tcc_cursor_type       cur
);

   localparam int COL_W  = tcc_pkg::COL_W;
   localparam int LINE_W = tcc_pkg::LINE_W;
   localparam int RECIP  = 65536 / TAB_STOP;
   localparam int PROD_W = COL_W + 17;
   localparam int QT_W   = COL_W + 5;
   localparam int REM_W  = $clog2(2 * TAB_STOP);

   logic [COL_W-1:0]  col_ff, col_in;
   logic [LINE_W-1:0] line_ff, line_in;
   logic [PROD_W-1:0] prod_ff, prod_in;
   logic [REM_W-1:0]  rem_ff, rem_in;
   logic              scroll;

   logic [LINE_W:0]   line_next;
   logic              line_over;
   logic [LINE_W-1:0] line_dn;
   logic [COL_W:0]    col_next;
   logic [COL_W-1:0]  quot;
   logic [QT_W-1:0]   rem_full;
   logic [REM_W-1:0]  rem_fix;
   logic [COL_W:0]    stop;

   assign line_next = {1'b0, line_ff} + (LINE_W + 1)'(1);
   assign line_over = line_next > {1'b0, last_line};
   assign line_dn   = line_over ? last_line : line_next[LINE_W-1:0];
   assign col_next  = {1'b0, col_ff} + (COL_W + 1)'(1);

   // floor reciprocal: quotient estimate is exact or one low
   assign quot     = prod_ff[COL_W+15:16];
   assign rem_full = QT_W'(col_ff) - QT_W'(quot) * QT_W'(TAB_STOP);
   assign rem_fix  = (rem_ff >= REM_W'(TAB_STOP)) ? rem_ff - REM_W'(TAB_STOP) : rem_ff;
   assign stop     = {1'b0, col_ff} + (COL_W + 1)'(TAB_STOP) - (COL_W + 1)'(rem_fix);

   always_comb begin
      col_in  = col_ff;
      line_in = line_ff;
      prod_in = prod_ff;
      rem_in  = rem_ff;
      scroll  = 1'b0;
      unique case (op)
         tcc_pkg::OP_NONE: begin
         end
         tcc_pkg::OP_ADVANCE: begin
            if (col_next > {1'b0, last_column}) begin
               col_in  = '0;
               line_in = line_dn;
               scroll  = line_over;
            end else begin
               col_in = col_next[COL_W-1:0];
            end
         end
         tcc_pkg::OP_NEWLINE: begin
            col_in  = '0;
            line_in = line_dn;
            scroll  = line_over;
         end
         tcc_pkg::OP_CR: begin
            col_in = '0;
         end
         tcc_pkg::OP_LINEDOWN: begin
            line_in = line_dn;
            scroll  = line_over;
         end
         tcc_pkg::OP_BACK: begin
            if (col_ff != '0) begin
               col_in = col_ff - COL_W'(1);
            end else if (line_ff != '0) begin
               line_in = line_ff - LINE_W'(1);
               col_in  = last_column;
            end
         end
         tcc_pkg::OP_TAB_MUL: begin
            prod_in = PROD_W'(col_ff) * PROD_W'(RECIP);
         end
         tcc_pkg::OP_TAB_REM: begin
            rem_in = rem_full[REM_W-1:0];
         end
         tcc_pkg::OP_TAB_APPLY: begin
            if (stop > {1'b0, last_column}) begin
               col_in  = '0;
               line_in = line_dn;
               scroll  = line_over;
            end else begin
               col_in = stop[COL_W-1:0];
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff  <= '0;
         line_ff <= '0;
      end else begin
         col_ff  <= col_in;
         line_ff <= line_in;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      rem_ff  <= rem_in;
   end

   assign cur.column = col_ff;
   assign cur.line   = line_ff;
   assign cur.scroll = scroll;

endmodule

@@ design/tcc_checker.sv @@
`timescale 1ns / 1ps
// port-level checks for the text console cursor controller, bound to the top
// depends on tcc_pkg and text_console_cursor_controller_top

module tcc_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            rsp_valid,
   input logic                            rsp_ready,
   input logic                            rsp_kind,
   input logic [tcc_pkg::CHAR_W-1:0]      rsp_glyph,
   input logic [tcc_pkg::COL_W-1:0]       rsp_column,
   input logic [tcc_pkg::LINE_W-1:0]      rsp_line,
   input logic [tcc_pkg::COLOR_W-1:0]     rsp_red,
   input logic [tcc_pkg::COLOR_W-1:0]     rsp_green,
   input logic [tcc_pkg::COLOR_W-1:0]     rsp_blue,
   input logic                            rsp_last
);

   // a result beat is held until taken
   a_rsp_hold : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result beat dropped before it was taken");

   // and its kind, glyph, position and last flag stay put while stalled
   a_rsp_stable : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_kind) && $stable(rsp_glyph) &&
         $stable(rsp_column) && $stable(rsp_line) && $stable(rsp_last))
      else $error("result payload changed under stall");

   // scroll beats carry no glyph, position or color
   a_scroll_zero : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind |-> rsp_glyph == '0 && rsp_column == '0 &&
         rsp_line == '0 && rsp_red == '0 && rsp_green == '0 && rsp_blue == '0)
      else $error("scroll beat with nonzero fields");

   // default gray is the only color with level cc, on all three channels
   a_gray : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_kind && rsp_red == tcc_pkg::GRAY_LEVEL |->
         rsp_green == tcc_pkg::GRAY_LEVEL && rsp_blue == tcc_pkg::GRAY_LEVEL)
      else $error("default gray drawn with mixed channels");

endmodule

bind text_console_cursor_controller_top tcc_checker u_tcc_checker (.*);

@@ test/testbench.sv @@
`timescale 1ns / 1ps
// self-checking bench for text_console_cursor_controller_top: feeds character bytes,
// predicts every draw and scroll beat and compares them; depends on tcc_pkg and the rtl

module testbench;
   import tcc_pkg::*;

   localparam int          ESC_DIGITS    = 6;
   localparam int          TAB_SPACING   = 8;
   localparam int          MAX_BEATS     = 16;   // most beats one byte can cause
   localparam int          SETTLE_CYCLES = 40;   // longest silent byte plus margin
   localparam int          HOLD_CYCLES   = 400;  // long receiver hold-off
   localparam int unsigned GRAY_SEL      = SEL_DEFAULT;

   // black, red, green, yellow, blue, magenta, cyan, white
   localparam logic [3*COLOR_W-1:0] COLOR_TABLE [8] = '{
      24'h000000, 24'h800000, 24'h008000, 24'h808000,
      24'h000080, 24'h800080, 24'h008080, 24'hffffff
   };

   typedef struct packed {
      logic               kind;
      logic [CHAR_W-1:0]  glyph;
      logic [COL_W-1:0]   column;
      logic [LINE_W-1:0]  line;
      logic [COLOR_W-1:0] red;
      logic [COLOR_W-1:0] green;
      logic [COLOR_W-1:0] blue;
      logic               last;
   } console_beat_type;

   // ------------------------------------------------------------------
   // block ports, all inputs known from time zero
   // ------------------------------------------------------------------
   logic                clock         = 1'b0;
   logic                reset         = 1'b1;
   logic                req_valid     = 1'b0;
   logic                req_ready;
   logic [CHAR_W-1:0]   req_char_code = '0;
   logic                rsp_valid;
   logic                rsp_ready     = 1'b0;
   logic                rsp_kind;
   logic [CHAR_W-1:0]   rsp_glyph;
   logic [COL_W-1:0]    rsp_column;
   logic [LINE_W-1:0]   rsp_line;
   logic [COLOR_W-1:0]  rsp_red;
   logic [COLOR_W-1:0]  rsp_green;
   logic [COLOR_W-1:0]  rsp_blue;
   logic                rsp_last;
   logic                csr_we        = 1'b0;
   logic                csr_index     = CSR_LAST_COLUMN;
   logic [CSR_W-1:0]    csr_wdata     = '0;

   text_console_cursor_controller_top #(
      .MAX_ESC_DIGITS(ESC_DIGITS),
      .TAB_STOP      (TAB_SPACING)
   ) u_dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_char_code(req_char_code),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_kind     (rsp_kind),
      .rsp_glyph    (rsp_glyph),
      .rsp_column   (rsp_column),
      .rsp_line     (rsp_line),
      .rsp_red      (rsp_red),
      .rsp_green    (rsp_green),
      .rsp_blue     (rsp_blue),
      .rsp_last     (rsp_last),
      .csr_we       (csr_we),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   // ------------------------------------------------------------------
   // console state as the bench sees it
   // ------------------------------------------------------------------
   int unsigned   lim_col   = RESET_LAST_COLUMN;
   int unsigned   lim_line  = RESET_LAST_LINE;
   int unsigned   cur_col   = 0;
   int unsigned   cur_line  = 0;
   int unsigned   color_sel = GRAY_SEL;
   tcc_phase_type parse_phase = PH_IDLE;
   int unsigned   digit_cnt = 0;
   int unsigned   held_digit [ESC_DIGITS];

   console_beat_type  step_beats[$];  // beats of the byte being predicted
   console_beat_type  draw_q[$];      // beats still owed by the block
   logic [CHAR_W-1:0] byte_q[$];      // bytes waiting for the driver

   int unsigned gap_pct    = 0;   // sender idle chance per cycle
   int unsigned stall_pct  = 0;   // receiver stall chance per cycle
   logic        rx_hold    = 1'b0;
   logic        hold_go    = 1'b0;
   int unsigned fail_count = 0;
   int unsigned queued     = 0;

   // ------------------------------------------------------------------
   // console predictor
   // ------------------------------------------------------------------
   function automatic void emit_beat(logic scroll, int unsigned g, int unsigned col,
                                     int unsigned ln);
      console_beat_type b;
      // the block never owes more than MAX_BEATS per byte
      if (step_beats.size() >= MAX_BEATS) return;
      b = '0;
      b.kind = scroll;
      // a scroll beat carries zeros everywhere else
      if (!scroll) begin
         b.glyph  = g[CHAR_W-1:0];
         b.column = col[COL_W-1:0];
         b.line   = ln[LINE_W-1:0];
         if (color_sel < 8) begin
            {b.red, b.green, b.blue} = COLOR_TABLE[color_sel];
         end else begin
            {b.red, b.green, b.blue} = {3{GRAY_LEVEL}};
         end
      end
      step_beats.push_back(b);
   endfunction

   // one line down, scrolling when it runs off the bottom (also clamps a line
   // left below a lowered bottom limit)
   function automatic void step_down();
      if (cur_line + 1 > lim_line) begin
         emit_beat(1'b1, 0, 0, 0);
         cur_line = lim_line;
      end else begin
         cur_line = cur_line + 1;
      end
   endfunction

   function automatic void wrap_line();
      cur_col = 0;
      step_down();
   endfunction

   // glyph at the cursor even if the cursor sits past a lowered right edge
   function automatic void draw_at_cursor(int unsigned g);
      emit_beat(1'b0, g, cur_col, cur_line);
      if (cur_col + 1 > lim_col) begin
         wrap_line();
      end else begin
         cur_col = cur_col + 1;
      end
   endfunction

   function automatic void plain_byte(logic [CHAR_W-1:0] c);
      int unsigned stop;
      case (c)
         CH_ESC: parse_phase = PH_ESC;
         CH_LF:  wrap_line();
         CH_CR:  cur_col = 0;
         CH_VT:  step_down();
         CH_BEL: ;  // bell: nothing to draw
         CH_BS: begin
            // at column 0 go to the end of the line above, stay put at home
            if (cur_col != 0) begin
               cur_col = cur_col - 1;
            end else if (cur_line != 0) begin
               cur_line = cur_line - 1;
               cur_col  = lim_col;
            end
         end
         CH_HT: begin
            stop = (cur_col / TAB_SPACING + 1) * TAB_SPACING;
            if (stop > lim_col) begin
               wrap_line();
            end else begin
               cur_col = stop;
            end
         end
         default: draw_at_cursor(c);
      endcase
   endfunction

   // failed sequence: ESC dropped, '[' and digits printed, then the byte itself
   function automatic void replay_sequence(logic [CHAR_W-1:0] c);
      parse_phase = PH_IDLE;
      draw_at_cursor(CH_LBR);
      for (int i = 0; i < digit_cnt && i < ESC_DIGITS; i++) begin
         draw_at_cursor(CH_ZERO + held_digit[i]);
      end
      digit_cnt = 0;
      plain_byte(c);
   endfunction

   // works out every beat one accepted byte causes and queues them in order
   function automatic void predict_byte(logic [CHAR_W-1:0] c);
      int unsigned      value;
      console_beat_type b;
      step_beats.delete();
      case (parse_phase)
         PH_ESC: begin
            if (c == CH_LBR) begin
               parse_phase = PH_CSI;
               digit_cnt   = 0;
            end else begin
               // lone ESC prints as a glyph, the byte is then taken as usual
               parse_phase = PH_IDLE;
               draw_at_cursor(CH_ESC);
               plain_byte(c);
            end
         end
         PH_CSI: begin
            if (c >= CH_ZERO && c <= CH_NINE && digit_cnt < ESC_DIGITS) begin
               held_digit[digit_cnt] = c - CH_ZERO;
               digit_cnt = digit_cnt + 1;
            end else if (c == CH_M && digit_cnt > 0) begin
               value = 0;
               for (int i = 0; i < digit_cnt; i++) begin
                  value = value * 10 + held_digit[i];
               end
               if (value == SGR_RESET) begin
                  color_sel   = GRAY_SEL;
                  parse_phase = PH_IDLE;
                  digit_cnt   = 0;
               end else if (value >= SGR_FG_FIRST && value <= SGR_FG_LAST) begin
                  color_sel   = value - SGR_FG_FIRST;
                  parse_phase = PH_IDLE;
                  digit_cnt   = 0;
               end else begin
                  replay_sequence(c);
               end
            end else begin
               // non-digit, digit overflow or 'm' with nothing held
               replay_sequence(c);
            end
         end
         default: plain_byte(c);
      endcase
      foreach (step_beats[i]) begin
         b      = step_beats[i];
         b.last = (i == step_beats.size() - 1);
         draw_q.push_back(b);
      end
   endfunction

   // ------------------------------------------------------------------
   // req driver: one byte per beat, valid held until taken
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            predict_byte(req_char_code);
         end
         if ((!req_valid || req_ready) && byte_q.size() != 0 &&
             $urandom_range(99) >= gap_pct) begin
            req_valid     <= 1'b1;
            req_char_code <= byte_q.pop_front();
         end else if (req_valid && req_ready) begin
            req_valid <= 1'b0;
         end
      end
   end

   // ------------------------------------------------------------------
   // rsp monitor: each beat against the oldest owed beat
   // ------------------------------------------------------------------
   function automatic void check_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         fail_count++;
      end
   endfunction

   always @(posedge clock) begin : rsp_monitor
      console_beat_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (draw_q.size() == 0) begin
               $error("beat with none owed: kind %0d glyph %0d column %0d line %0d",
                      rsp_kind, rsp_glyph, rsp_column, rsp_line);
               fail_count++;
            end else begin
               want = draw_q.pop_front();
               check_field("kind",   want.kind,   rsp_kind);
               check_field("glyph",  want.glyph,  rsp_glyph);
               check_field("column", want.column, rsp_column);
               check_field("line",   want.line,   rsp_line);
               check_field("red",    want.red,    rsp_red);
               check_field("green",  want.green,  rsp_green);
               check_field("blue",   want.blue,   rsp_blue);
               check_field("last",   want.last,   rsp_last);
            end
         end
         rsp_ready <= !rx_hold && ($urandom_range(99) >= stall_pct);
      end
   end

   // long receiver hold-off while the sender keeps offering bytes
   initial begin
      wait (hold_go);
      @(posedge clock);
      rx_hold <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      rx_hold <= 1'b0;
   end

   // ------------------------------------------------------------------
   // stimulus helpers
   // ------------------------------------------------------------------
   function automatic void push_byte(logic [CHAR_W-1:0] c);
      byte_q.push_back(c);
      queued++;
   endfunction

   // decimal digits of v, zero padded to at least width digits
   function automatic void push_number(int unsigned v, int unsigned width);
      logic [CHAR_W-1:0] digs[$];
      do begin
         digs.push_front(CHAR_W'(CH_ZERO + v % 10));
         v = v / 10;
      end while (v != 0);
      while (digs.size() < width) digs.push_front(CH_ZERO);
      foreach (digs[i]) push_byte(digs[i]);
   endfunction

   // limits change only while the block is idle
   task automatic set_limits(int unsigned col, int unsigned ln);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= CSR_LAST_COLUMN;
      csr_wdata <= col[CSR_W-1:0];
      @(posedge clock);
      lim_col = col;
      csr_index <= CSR_LAST_LINE;
      csr_wdata <= ln[CSR_W-1:0];
      @(posedge clock);
      lim_line = ln;
      csr_we <= 1'b0;
   endtask

   // sender drained, every owed beat in, then time for a silent last byte;
   // sampled between edges so the driver and monitor updates have settled
   task automatic wait_idle();
      while (byte_q.size() != 0 || req_valid || draw_q.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic add_directed();
      push_byte("A");
      push_byte(8'hff);
      push_byte(CH_BEL);
      push_byte(CH_HT);
      push_byte(CH_BS);
      push_byte(CH_CR);
      push_byte(CH_LF);
      push_byte(CH_VT);
      push_byte(CH_BS);   // column 0 on a lower line: end of the line above
      push_byte(CH_CR);
      push_byte(CH_BS);   // home: stays put
      push_byte(CH_ESC);  // ESC without '['
      push_byte("x");
      push_byte(CH_ESC);  // red
      push_byte(CH_LBR);
      push_byte("3");
      push_byte("1");
      push_byte(CH_M);
      push_byte(CH_ESC);  // 'm' with no digits fails
      push_byte(CH_LBR);
      push_byte(CH_M);
      push_byte(CH_ESC);  // back to gray
      push_byte(CH_LBR);
      push_byte("0");
      push_byte(CH_M);
   endtask

   // mostly well-formed text and color sequences, some noise and broken ones
   task automatic add_random(int unsigned count);
      int unsigned start;
      int unsigned pick;
      start = queued;
      while (queued - start < count) begin
         pick = $urandom_range(99);
         if (pick < 25) begin
            repeat ($urandom_range(6, 1)) push_byte(CHAR_W'($urandom_range(126, 32)));
         end else if (pick < 40) begin
            case ($urandom_range(5))
               0: push_byte(CH_BEL);
               1: push_byte(CH_BS);
               2: push_byte(CH_HT);
               3: push_byte(CH_LF);
               4: push_byte(CH_VT);
               default: push_byte(CH_CR);
            endcase
         end else if (pick < 70) begin
            push_byte(CH_ESC);
            push_byte(CH_LBR);
            if ($urandom_range(3) == 0) begin
               push_number(SGR_RESET, $urandom_range(ESC_DIGITS, 1));
            end else begin
               push_number(SGR_FG_FIRST + $urandom_range(7), $urandom_range(ESC_DIGITS, 1));
            end
            push_byte(CH_M);
         end else if (pick < 92) begin
            push_byte(CH_ESC);
            case ($urandom_range(5))
               0: push_byte(CHAR_W'($urandom_range(255)));
               1: begin
                  push_byte(CH_LBR);
                  push_byte(CH_M);
               end
               2: begin
                  // digits cut off by an arbitrary byte
                  push_byte(CH_LBR);
                  push_number($urandom_range(999), $urandom_range(3, 1));
                  push_byte(CHAR_W'($urandom_range(255)));
               end
               3: begin
                  // one digit too many
                  push_byte(CH_LBR);
                  repeat (ESC_DIGITS + 1) push_byte(CHAR_W'(CH_ZERO + $urandom_range(9)));
                  push_byte(CH_M);
               end
               4: begin
                  // well formed but not a known color
                  push_byte(CH_LBR);
                  if ($urandom_range(1) == 0) begin
                     push_number($urandom_range(SGR_FG_FIRST - 1, 1), 1);
                  end else begin
                     push_number($urandom_range(999999, SGR_OVER), 1);
                  end
                  push_byte(CH_M);
               end
               default: begin
                  // a new ESC interrupts the sequence and starts its own
                  push_byte(CH_LBR);
                  push_number($urandom_range(99), 1);
                  push_byte(CH_ESC);
                  push_byte(CH_LBR);
                  push_number(SGR_FG_FIRST + $urandom_range(7), 2);
                  push_byte(CH_M);
               end
            endcase
         end else begin
            push_byte(CHAR_W'($urandom_range(255)));
         end
      end
   endtask

   // ------------------------------------------------------------------
   // clock, reset and the run
   // ------------------------------------------------------------------
   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // reset limits, no idling on either side
      add_directed();
      add_random(65);
      wait_idle();

      // smallest screen: every glyph wraps and scrolls; sender idles
      set_limits(0, 0);
      gap_pct <= 63;
      add_random(55);
      wait_idle();

      // largest screen; receiver stalls, with a sender pause mid-phase
      set_limits(1023, 1023);
      gap_pct   <= 0;
      stall_pct <= 63;
      add_random(35);
      wait_idle();
      add_random(35);
      wait_idle();

      // shrink below the cursor; light idling both ways plus the long hold-off
      set_limits(9, 3);
      gap_pct   <= 13;
      stall_pct <= 13;
      hold_go = 1'b1;
      add_random(95);
      wait_idle();

      // narrow two-line screen at full rate
      set_limits(40, 1);
      gap_pct   <= 0;
      stall_pct <= 0;
      add_random(80);
      wait_idle();

      if (fail_count == 0 && draw_q.size() == 0) begin
         $display("testbench OK");
      end else begin
         $display("testbench NOT OK");
      end
      $finish;
   end

   // run limit, far beyond the slowest correct run
   initial begin
      #5_000_000;
      $display("testbench NOT OK");
      $finish;
   end

endmodule
